// ----- hdl/alq_pkg.sv -----
// Shared types, constants and index helpers of the adaptive-limit message queue.
package alq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int FIELD_W     = 6;
   localparam int HANDLE_W    = 32;
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   localparam logic [1:0] ACT_PUT_TAIL = 2'd0;
   localparam logic [1:0] ACT_PUT_HEAD = 2'd1;
   localparam logic [1:0] ACT_GET      = 2'd2;
   localparam logic [1:0] ACT_DRAIN    = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1);

   typedef enum logic [1:0] {
      CMD_PUT_TAIL,
      CMD_PUT_HEAD,
      CMD_GET,
      CMD_DRAIN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [HANDLE_W-1:0] handle;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [HANDLE_W-1:0] message_out;
      logic                last_item;
      logic [FIELD_W-1:0]  occupancy;
      logic [FIELD_W-1:0]  current_limit;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_POP
   } back_state_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      if (idx == '0) begin
         return IDX_W'(QUEUE_DEPTH - 1);
      end
      return idx - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cnt);
      logic [IDX_W:0] sum;
      sum = {1'b0, idx} + (IDX_W + 1)'(cnt);
      if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- hdl/alq_if.sv -----
// Channel interfaces of the adaptive-limit message queue.
interface alq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [31:0] message_handle;

   modport source (output valid, output action, output message_handle, input ready);
   modport sink   (input valid, input action, input message_handle, output ready);
endinterface

interface alq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] message_out;
   logic        last_item;
   logic [5:0]  occupancy;
   logic [5:0]  current_limit;

   modport source (output valid, output status, output message_out, output last_item,
                   output occupancy, output current_limit, input ready);
   modport sink   (input valid, input status, input message_out, input last_item,
                   input occupancy, input current_limit, output ready);
endinterface

interface alq_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] limit_setting;

   modport source (output valid, output limit_setting, input ready);
   modport sink   (input valid, input limit_setting, output ready);
endinterface

// ----- hdl/alq_front.sv -----
// Front end: accepts requests, decodes the action and queues commands for the back end.
module alq_front (
   input  logic             clock,
   input  logic             reset,
   alq_req_if.sink          req_bus,
   output logic             cmd_valid,
   output alq_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import alq_pkg::*;

   cmd_type              fifo_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] fill_ff, fill_in;
   logic                 push;
   logic                 pop;
   cmd_type              decoded;

   function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] ptr);
      if (ptr == CMD_PTR_W'(CMD_DEPTH - 1)) begin
         return '0;
      end
      return ptr + CMD_PTR_W'(1);
   endfunction

   always_comb begin
      case (req_bus.action)
         ACT_PUT_TAIL: decoded.kind = CMD_PUT_TAIL;
         ACT_PUT_HEAD: decoded.kind = CMD_PUT_HEAD;
         ACT_GET:      decoded.kind = CMD_GET;
         ACT_DRAIN:    decoded.kind = CMD_DRAIN;
         default:      decoded.kind = CMD_GET;
      endcase
      decoded.handle = req_bus.message_handle;
   end

   assign req_bus.ready = (fill_ff != CMD_CNT_W'(CMD_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (fill_ff != '0);
   assign pop           = cmd_valid && cmd_take;
   assign cmd           = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CMD_CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- hdl/alq_back.sv -----
// Back end: queue state, handle store, limit logic and the response register.
module alq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  alq_pkg::cmd_type cmd,
   output logic             cmd_take,
   alq_csr_if.sink          csr_bus,
   alq_rsp_if.source        rsp_bus
);
   import alq_pkg::*;

   logic [HANDLE_W-1:0] mem [QUEUE_DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic                grow_ff, grow_in;
   logic                drain_ff, drain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                out_free;
   logic                out_load;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   logic                full;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      limit_in  = limit_ff;
      grow_in   = grow_ff;
      drain_in  = drain_ff;
      rsp_in    = rsp_ff;
      out_load  = 1'b0;
      cmd_take  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_add(head_ff, count_ff);
      mem_re    = 1'b0;
      mem_raddr = head_ff;
      full      = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               out_load = 1'b1;
               rsp_in.message_out = '0;
               rsp_in.last_item   = 1'b1;
               case (cmd.kind)
                  CMD_PUT_TAIL, CMD_PUT_HEAD: begin
                     if (limit_ff != '0 && count_ff >= limit_ff && grow_ff
                         && limit_ff < DEPTH_CNT) begin
                        grow_in  = 1'b0;
                        limit_in = limit_ff + CNT_W'(1);
                     end
                     full = (count_ff >= DEPTH_CNT) ||
                            (limit_in != '0 && count_ff >= limit_in);
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_DONE;
                        mem_we        = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        if (cmd.kind == CMD_PUT_HEAD) begin
                           head_in   = idx_dec(head_ff);
                           mem_waddr = idx_dec(head_ff);
                        end
                     end
                  end
                  CMD_GET, CMD_DRAIN: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        out_load = 1'b0;
                        mem_re   = 1'b1;
                        drain_in = (cmd.kind == CMD_DRAIN);
                        state_in = BK_POP;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_EMPTY;
                  end
               endcase
               rsp_in.occupancy     = FIELD_W'(count_in);
               rsp_in.current_limit = FIELD_W'(limit_in);
            end
         end
         BK_POP: begin
            if (out_free) begin
               out_load = 1'b1;
               head_in  = idx_inc(head_ff);
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  grow_in = 1'b1;
               end
               rsp_in.status        = ST_DONE;
               rsp_in.message_out   = rd_data_ff;
               rsp_in.last_item     = !drain_ff || (count_ff == CNT_W'(1));
               rsp_in.occupancy     = FIELD_W'(count_in);
               rsp_in.current_limit = FIELD_W'(limit_ff);
               if (drain_ff && count_ff != CNT_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_inc(head_ff);
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (csr_bus.valid) begin
         if (int'(csr_bus.limit_setting) > QUEUE_DEPTH) begin
            limit_in = DEPTH_CNT;
         end else begin
            limit_in = CNT_W'(csr_bus.limit_setting);
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         grow_ff      <= 1'b0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         grow_ff      <= grow_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.handle;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_ff.status;
   assign rsp_bus.message_out   = rsp_ff.message_out;
   assign rsp_bus.last_item     = rsp_ff.last_item;
   assign rsp_bus.occupancy     = rsp_ff.occupancy;
   assign rsp_bus.current_limit = rsp_ff.current_limit;

endmodule

// ----- hdl/adaptive_limit_message_queue.sv -----
// Top level of the adaptive-limit message queue.
//
//   Channel   Direction   Carries
//   req_bus   in          action, message_handle
//   rsp_bus   out         status, message_out, last_item, occupancy, current_limit
//   csr_bus   in          limit_setting
//
// A put, or a get or drain on an empty queue, is answered from the idle state; a get goes
// through the pop state too, as the handle store has a registered read port; a drain stays
// in the pop state until the queue is empty. The two-entry command queue sits in front.
// Reset is synchronous; the handle store is not cleared and needs no clearing pass.
// A stall on rsp_bus holds the response register and the back end, while the command
// queue goes on taking requests until it is full.
module adaptive_limit_message_queue (
   input logic       clock,
   input logic       reset,
   alq_req_if.sink   req_bus,
   alq_rsp_if.source rsp_bus,
   alq_csr_if.sink   csr_bus
);
   import alq_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   alq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   alq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .csr_bus   (csr_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- hdl/alq_checker.sv -----
// Port-level checks of the adaptive-limit message queue and their binding.
module alq_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_message_out,
   input logic        rsp_last_item,
   input logic [5:0]  rsp_occupancy,
   input logic [5:0]  rsp_current_limit
);
   import alq_pkg::*;

   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response offered straight after reset.");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_message_out) && $stable(rsp_last_item)
         && $stable(rsp_occupancy) && $stable(rsp_current_limit))
      else $error("Stalled response changed.");

   a_no_handle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_message_out == '0 && rsp_last_item)
      else $error("Refused or empty response carries a handle or is not final.");

   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
      else $error("Empty status with a nonzero occupancy.");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy != '0)
      else $error("Full status with an empty queue.");

endmodule

bind adaptive_limit_message_queue alq_port_checks u_alq_port_checks (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_message_out   (rsp_bus.message_out),
   .rsp_last_item     (rsp_bus.last_item),
   .rsp_occupancy     (rsp_bus.occupancy),
   .rsp_current_limit (rsp_bus.current_limit)
);

// ----- tb/alq_checker.sv -----
`timescale 1ns / 1ps
// Checker of the message queue: it mirrors the queue state and compares every response.
module alq_checker
   import alq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [HANDLE_W-1:0] req_handle,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_status,
   input  logic [HANDLE_W-1:0] rsp_message_out,
   input  logic                rsp_last_item,
   input  logic [FIELD_W-1:0]  rsp_occupancy,
   input  logic [FIELD_W-1:0]  rsp_current_limit,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [FIELD_W-1:0]  csr_limit_setting,
   output int                  failure_count,
   output int                  pending_count
);

   logic [HANDLE_W-1:0] shadow_store [QUEUE_DEPTH];
   int                  shadow_head;
   logic [FIELD_W-1:0]  shadow_count;
   logic [FIELD_W-1:0]  shadow_limit;
   logic                shadow_grow;
   rsp_type             expected_rsps [$];

   initial begin
      failure_count = 0;
      pending_count = 0;
   end

   task automatic push_expected(input logic [1:0] status, input logic [HANDLE_W-1:0] handle,
                                input logic last);
      rsp_type entry;
      entry.status        = status;
      entry.message_out   = handle;
      entry.last_item     = last;
      entry.occupancy     = shadow_count;
      entry.current_limit = shadow_limit;
      expected_rsps.push_back(entry);
   endtask

   task automatic take_head(output logic [HANDLE_W-1:0] handle);
      handle       = shadow_store[shadow_head];
      shadow_head  = (shadow_head + 1) % QUEUE_DEPTH;
      shadow_count = shadow_count - 1'b1;
      if (shadow_count == '0) begin
         shadow_grow = 1'b1;
      end
   endtask

   task automatic predict_request(input logic [1:0] act, input logic [HANDLE_W-1:0] handle);
      logic                full;
      logic [HANDLE_W-1:0] taken;
      if (act == ACT_PUT_TAIL || act == ACT_PUT_HEAD) begin
         if (shadow_limit != '0 && shadow_count >= shadow_limit && shadow_grow &&
             shadow_limit < FIELD_W'(QUEUE_DEPTH)) begin
            shadow_grow  = 1'b0;
            shadow_limit = shadow_limit + 1'b1;
         end
         full = (shadow_count >= FIELD_W'(QUEUE_DEPTH)) ||
                (shadow_limit != '0 && shadow_count >= shadow_limit);
         if (full) begin
            push_expected(ST_FULL, '0, 1'b1);
         end else begin
            if (act == ACT_PUT_TAIL) begin
               shadow_store[(shadow_head + int'(shadow_count)) % QUEUE_DEPTH] = handle;
            end else begin
               shadow_head = (shadow_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               shadow_store[shadow_head] = handle;
            end
            shadow_count = shadow_count + 1'b1;
            push_expected(ST_DONE, '0, 1'b1);
         end
      end else if (shadow_count == '0) begin
         push_expected(ST_EMPTY, '0, 1'b1);
      end else if (act == ACT_GET) begin
         take_head(taken);
         push_expected(ST_DONE, taken, 1'b1);
      end else begin
         while (shadow_count != '0) begin
            take_head(taken);
            push_expected(ST_DONE, taken, shadow_count == '0);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failure_count++;
      end
   endtask

   task automatic check_response();
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         $error("response with no request outstanding: status %0d, message_out %0h",
                rsp_status, rsp_message_out);
         failure_count++;
      end else begin
         want = expected_rsps[0];
         expected_rsps.delete(0);
         check_field("status", 32'(want.status), 32'(rsp_status));
         check_field("message_out", want.message_out, rsp_message_out);
         check_field("last_item", 32'(want.last_item), 32'(rsp_last_item));
         check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         check_field("current_limit", 32'(want.current_limit), 32'(rsp_current_limit));
      end
   endtask

   always @(posedge clock) begin : monitor
      if (reset) begin
         shadow_head  = 0;
         shadow_count = '0;
         shadow_limit = LIMIT_RESET;
         shadow_grow  = 1'b0;
         expected_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_limit_setting > FIELD_W'(QUEUE_DEPTH)) begin
               shadow_limit = FIELD_W'(QUEUE_DEPTH);
            end else begin
               shadow_limit = csr_limit_setting;
            end
         end
         if (rsp_valid && rsp_ready) begin
            check_response();
         end
         if (req_valid && req_ready) begin
            predict_request(req_action, req_handle);
         end
      end
      pending_count <= expected_rsps.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top of the message queue: clock, reset, request and response traffic, verdict.
module tb_top;
   import alq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          failure_count;
   int          pending_count;
   int unsigned sent_total = 0;
   bit          calm = 1'b0;
   bit          long_hold = 1'b0;

   alq_req_if req_bus ();
   alq_rsp_if rsp_bus ();
   alq_csr_if csr_bus ();

   adaptive_limit_message_queue DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   alq_checker queue_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_action        (req_bus.action),
      .req_handle        (req_bus.message_handle),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_message_out   (rsp_bus.message_out),
      .rsp_last_item     (rsp_bus.last_item),
      .rsp_occupancy     (rsp_bus.occupancy),
      .rsp_current_limit (rsp_bus.current_limit),
      .csr_valid         (csr_bus.valid),
      .csr_ready         (csr_bus.ready),
      .csr_limit_setting (csr_bus.limit_setting),
      .failure_count     (failure_count),
      .pending_count     (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [HANDLE_W-1:0] random_handle();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return '1;
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] random_put();
      return ($urandom_range(0, 1) == 0) ? ACT_PUT_TAIL : ACT_PUT_HEAD;
   endfunction

   function automatic logic [1:0] random_action();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return random_put();
      end
      if (pick < 8) begin
         return ACT_GET;
      end
      return ACT_DRAIN;
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [HANDLE_W-1:0] handle);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.action         <= act;
      req_bus.message_handle <= handle;
      do @(posedge clock); while (!req_bus.ready);
      sent_total++;
   endtask

   task automatic wait_quiet(input int unsigned settle);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_limit(input logic [FIELD_W-1:0] value);
      wait_quiet(4);
      csr_bus.valid         <= 1'b1;
      csr_bus.limit_setting <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : receiver
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      logic [FIELD_W-1:0] settings [8];
      int unsigned        phase_start;
      int unsigned        burst_len;
      int unsigned        takes;
      req_bus.valid          <= 1'b0;
      req_bus.action         <= ACT_PUT_TAIL;
      req_bus.message_handle <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.limit_setting  <= '0;
      settings = '{6'd2, 6'd0, 6'd32, 6'd1, 6'd63, 6'd33, 6'd31, 6'd0};
      settings[7] = FIELD_W'($urandom_range(0, 63));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Empty queue, the reset limit of one, refusal without and growth with the grow mark.
      send_request(ACT_GET, 32'h0000_0000);
      send_request(ACT_DRAIN, 32'hFFFF_FFFF);
      send_request(ACT_PUT_TAIL, 32'h0000_0000);
      send_request(ACT_PUT_TAIL, 32'hFFFF_FFFF);
      send_request(ACT_GET, 32'h0000_0000);
      send_request(ACT_PUT_HEAD, 32'hFFFF_FFFF);
      send_request(ACT_PUT_TAIL, 32'hA5A5_A5A5);
      send_request(ACT_PUT_HEAD, 32'h5A5A_5A5A);
      send_request(ACT_DRAIN, 32'h0000_0000);

      // An oversized setting saturates at the physical depth.
      write_limit(6'd63);
      send_request(ACT_PUT_TAIL, 32'h1234_5678);
      send_request(ACT_PUT_HEAD, 32'hFFFF_FFFF);
      send_request(ACT_PUT_TAIL, 32'h0000_0000);
      send_request(ACT_GET, 32'hFFFF_FFFF);
      send_request(ACT_DRAIN, 32'h0000_0000);

      write_limit(6'd0);
      send_request(ACT_PUT_HEAD, 32'h8000_0001);
      send_request(ACT_PUT_TAIL, 32'h7FFF_FFFE);
      send_request(ACT_PUT_HEAD, 32'hFFFF_FFFF);
      send_request(ACT_GET, 32'h0000_0000);
      send_request(ACT_DRAIN, 32'hFFFF_FFFF);

      for (int p = 0; p < 8; p++) begin
         write_limit(settings[p]);
         if (p == 1 || p == 5) begin
            long_hold = 1'b1;
         end
         phase_start = sent_total;
         while (sent_total - phase_start < 18) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 4) begin
               burst_len = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 34)
                                                       : $urandom_range(1, 8);
               repeat (burst_len) send_request(random_put(), random_handle());
               if ($urandom_range(0, 1) == 0) begin
                  send_request(ACT_DRAIN, random_handle());
               end else begin
                  takes = $urandom_range(1, burst_len + 1);
                  repeat (takes) send_request(ACT_GET, random_handle());
               end
            end else begin
               send_request(random_action(), random_handle());
            end
         end
      end

      wait_quiet(16);
      if (failure_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
